// ===== hw/rtl/sisd_pkg.sv =====
// Shared types for the sorted insert store and drain unit.
`timescale 1ns / 1ps
`default_nettype none

package sisd_pkg;

	// Status bits that travel with each drained key.
	typedef struct packed {
		logic final_key;
		logic overflowed;
	} out_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_insert_store_drain_unit.sv =====
// Top level: sorted key store with iterative insert and a drain sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid / in_ready    | item_key, end_of_set
//  out     | output    | out_valid / out_ready  | sorted_key, final_key, overflowed
//
// An insert walks the store from the top down with one shared compare, reading each
// stored key it compares and shifting it up until the key lands or reaches the bottom.
// An insert into a full store is dropped in the cycle it is accepted.
// A drain reads each stored key through the single memory read port before presenting it.
// Reset empties the store and clears the overflow flag; no clearing pass is needed.
// The block takes no input beat while it inserts or drains; the drain stalls on out_ready.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_store_drain_unit #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KEY_BITS-1:0] item_key,
	input  wire logic                end_of_set,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [KEY_BITS-1:0]      sorted_key,
	output logic                     final_key,
	output logic                     overflowed
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);
	localparam logic [CNTW-1:0] ONE_CNT  = CNTW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DRD,
		ST_DOUT
	} state_t;

	state_t              state_q;
	logic [KEY_BITS-1:0] key_q;
	logic                drain_q;
	logic [CNTW-1:0]     idx_q;
	logic [CNTW-1:0]     fill_q;
	logic                ovf_q;

	logic [KEY_BITS-1:0] mem [DEPTH];
	logic [KEY_BITS-1:0] rdata_q;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_data;
	logic                moves_up;
	logic                last_out;
	sisd_pkg::out_flags_t flags;

	// The one compare unit: does the stored key at the walk position move up?
	assign moves_up = (rdata_q >= key_q);
	assign last_out = (idx_q == (fill_q - ONE_CNT));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = key_q;
		case (state_q)
			ST_READ: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_q - ONE_CNT);
				end
			end
			ST_CMP: begin
				wr_en = 1'b1;
				if (moves_up) begin
					wr_data = rdata_q;
				end
			end
			ST_DRD: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
			key_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= item_key;
						drain_q <= end_of_set;
						idx_q   <= '0;
						if (fill_q == FULL_CNT) begin
							ovf_q <= 1'b1;
							if (end_of_set) begin
								state_q <= ST_DRD;
							end
						end else begin
							idx_q   <= fill_q;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (idx_q == '0) begin
						fill_q  <= fill_q + ONE_CNT;
						state_q <= drain_q ? ST_DRD : ST_IDLE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (moves_up) begin
						idx_q   <= idx_q - ONE_CNT;
						state_q <= ST_READ;
					end else begin
						fill_q  <= fill_q + ONE_CNT;
						idx_q   <= '0;
						state_q <= drain_q ? ST_DRD : ST_IDLE;
					end
				end
				ST_DRD: begin
					state_q <= ST_DOUT;
				end
				ST_DOUT: begin
					if (out_ready) begin
						if (last_out) begin
							fill_q  <= '0;
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + ONE_CNT;
							state_q <= ST_DRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The idle pass of the READ state is taken only after a full-store check, so the
	// first walk step after an accepted beat never runs with idx_q ahead of fill_q.
	assign flags.final_key  = last_out;
	assign flags.overflowed = ovf_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_DOUT);
	assign sorted_key = rdata_q;
	assign final_key  = flags.final_key;
	assign overflowed = flags.overflowed;

endmodule

`default_nettype wire

// ===== hw/rtl/sisd_checker.sv =====
// Port-level checker for the sorted insert store and drain unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module sisd_checker #(
	parameter int KEY_BITS = 8
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                end_of_set,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [KEY_BITS-1:0] sorted_key,
	input wire logic                final_key,
	input wire logic                overflowed
);

	sisd_pkg::out_flags_t flags;
	assign flags.final_key  = final_key;
	assign flags.overflowed = overflowed;

	// A stalled output beat keeps its key and status.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sorted_key) && $stable(flags))
		else $error("stalled output beat changed");

	// The block never takes input while it is draining.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during drain");

	// A beat that ends the set always starts a drain.
	a_drain_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_set |=> !in_ready)
		else $error("ready right after end of set");

	// Once the last key of a drain is taken, the block is ready again.
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_key |=> in_ready && !out_valid)
		else $error("block not idle after final key");

	// The overflow flag is sticky across drained beats.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |=> !out_valid || overflowed)
		else $error("overflow flag dropped");

endmodule

bind sorted_insert_store_drain_unit sisd_checker #(
	.KEY_BITS(KEY_BITS)
) u_sisd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.end_of_set(end_of_set),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sorted_key(sorted_key),
	.final_key (final_key),
	.overflowed(overflowed)
);

`default_nettype wire
